FILE: design/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted tick queue
// Operation and status codes, controller states and the per-cell control
// bundle that the top level drives into the row of cells.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int STQ_CAPACITY = 16;
   localparam int STQ_KEY_BITS = 32;
   localparam int STQ_ID_BITS  = 8;

   typedef enum logic [1:0] {
      OP_SORTED = 2'd0,
      OP_TAIL   = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE,
      S_REPLY
   } state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic capture;    // latch this cell's hit flag
      logic by_key;     // hit on the first entry with a larger key
      logic by_id;      // hit on the first entry with a matching id
      logic do_insert;  // open a gap at the first hit, shift toward the tail
      logic do_remove;  // drop the first hit, shift toward the head
   } cell_ctl_type;

endpackage

FILE: design/stq_req_if.sv
// ----------------------------------------------------------------------------
// stq_req_if: operation channel of the sorted tick queue
// Valid/ready channel carrying one queue operation per transfer.
// ----------------------------------------------------------------------------
interface stq_req_if
   import stq_pkg::*;
#(
   parameter int KEY_BITS = STQ_KEY_BITS,
   parameter int ID_BITS  = STQ_ID_BITS
);
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [ID_BITS-1:0]  item_id;
   logic [KEY_BITS-1:0] sort_key;

   modport source (output valid, output op, output item_id, output sort_key, input ready);
   modport sink   (input valid, input op, input item_id, input sort_key, output ready);
endinterface

FILE: design/stq_rsp_if.sv
// ----------------------------------------------------------------------------
// stq_rsp_if: result channel of the sorted tick queue
// Valid/ready channel carrying the count, status and head entry.
// ----------------------------------------------------------------------------
interface stq_rsp_if
   import stq_pkg::*;
#(
   parameter int CAPACITY = STQ_CAPACITY,
   parameter int KEY_BITS = STQ_KEY_BITS,
   parameter int ID_BITS  = STQ_ID_BITS
);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   logic                valid;
   logic                ready;
   logic [CNT_BITS-1:0] entry_count;
   logic [1:0]          status;
   logic                head_valid;
   logic [KEY_BITS-1:0] head_key;
   logic [ID_BITS-1:0]  head_id;

   modport source (output valid, output entry_count, output status, output head_valid,
                   output head_key, output head_id, input ready);
   modport sink   (input valid, input entry_count, input status, input head_valid,
                   input head_key, input head_id, output ready);
endinterface

FILE: design/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell: one slot of the ordered list
// Holds one entry, flags whether it is the insert/remove point and takes
// data from its left or right neighbor when the list shifts.
// ----------------------------------------------------------------------------
module stq_cell
   import stq_pkg::*;
#(
   parameter int KEY_BITS = STQ_KEY_BITS,
   parameter int ID_BITS  = STQ_ID_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctl_type        ctl,
   input  logic [KEY_BITS-1:0] new_key,
   input  logic [ID_BITS-1:0]  new_id,
   input  logic                left_valid,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [ID_BITS-1:0]  left_id,
   input  logic                right_valid,
   input  logic [KEY_BITS-1:0] right_key,
   input  logic [ID_BITS-1:0]  right_id,
   input  logic                prior_in,
   output logic                prior_out,
   output logic                slot_valid,
   output logic [KEY_BITS-1:0] slot_key,
   output logic [ID_BITS-1:0]  slot_id
);

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic                hit_ff, hit_in;
   logic                first;

   always_comb begin
      if (ctl.by_key) begin
         hit_in = !valid_ff || (key_ff > new_key);
      end else if (ctl.by_id) begin
         hit_in = valid_ff && (id_ff == new_id);
      end else begin
         hit_in = !valid_ff;
      end
   end

   assign first     = hit_ff && !prior_in;
   assign prior_out = prior_in || hit_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      id_in    = id_ff;
      if (ctl.do_insert) begin
         if (first) begin
            valid_in = 1'b1;
            key_in   = new_key;
            id_in    = new_id;
         end else if (prior_in) begin
            valid_in = left_valid;
            key_in   = left_key;
            id_in    = left_id;
         end
      end else if (ctl.do_remove && prior_out) begin
         valid_in = right_valid;
         key_in   = right_key;
         id_in    = right_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctl.capture) begin
            hit_ff <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign slot_valid = valid_ff;
   assign slot_key   = key_ff;
   assign slot_id    = id_ff;

endmodule

FILE: design/sorted_tick_queue.sv
// ----------------------------------------------------------------------------
// sorted_tick_queue: bounded ordered list of (key, id) entries
// Row of list cells with a small controller that runs one operation at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one operation per transfer: sorted insert (after every
//   entry with a key less than or equal), tail insert, or remove of the first
//   entry with a given id. A sorted insert of the all-ones key goes to the tail.
//   rsp_chan returns one result per operation: entry count, status (done,
//   full, not found) and the head entry (zero when the list is empty).
// Timing:
//   Each operation steps through accept, a parallel compare in every cell,
//   a shift of the row, then a load of the result register. The result is
//   registered before it shows on rsp_chan; a new request is taken once the
//   controller is back in idle, even while the previous result still waits.
//   These steps follow from the compare and shift passes over the cell row.
// Reset:
//   Synchronous, active high; empties the list and drops any pending result.
// Stall:
//   A held result stays on rsp_chan; the next operation completes its shift
//   and then waits in its reply step until the result register frees up.
// ----------------------------------------------------------------------------
module sorted_tick_queue
   import stq_pkg::*;
#(
   parameter int CAPACITY = STQ_CAPACITY,
   parameter int KEY_BITS = STQ_KEY_BITS,
   parameter int ID_BITS  = STQ_ID_BITS
) (
   input  logic      clock,
   input  logic      reset,
   stq_req_if.sink   req_chan,
   stq_rsp_if.source rsp_chan
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);
   localparam logic [KEY_BITS-1:0] TAIL_KEY   = {KEY_BITS{1'b1}};

   state_type state_ff, state_in;

   // captured request
   logic [1:0]          op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [ID_BITS-1:0]  id_ff;

   logic [CNT_BITS-1:0] count_ff, count_in;
   status_type          status_ff, status_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_BITS-1:0] rsp_count_ff;
   status_type          rsp_status_ff;
   logic                rsp_head_valid_ff;
   logic [KEY_BITS-1:0] rsp_head_key_ff;
   logic [ID_BITS-1:0]  rsp_head_id_ff;

   cell_ctl_type        ctl;
   logic                accept;
   logic                load_rsp;
   logic                is_insert;
   logic                found;

   logic [CAPACITY-1:0] cell_valid;
   logic [KEY_BITS-1:0] cell_key [CAPACITY];
   logic [ID_BITS-1:0]  cell_id  [CAPACITY];
   logic [CAPACITY:0]   prior;

   assign accept    = req_chan.valid && req_chan.ready;
   assign is_insert = (op_ff == OP_SORTED) || (op_ff == OP_TAIL);
   assign found     = prior[CAPACITY];
   assign load_rsp  = (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_chan.ready);
   assign prior[0]  = 1'b0;

   // ---------------- cell row ----------------
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_valid, right_valid;
      logic [KEY_BITS-1:0] left_key, right_key;
      logic [ID_BITS-1:0]  left_id, right_id;

      if (i == 0) begin : g_head
         assign left_valid = 1'b0;
         assign left_key   = '0;
         assign left_id    = '0;
      end else begin : g_mid
         assign left_valid = cell_valid[i-1];
         assign left_key   = cell_key[i-1];
         assign left_id    = cell_id[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_key   = '0;
         assign right_id    = '0;
      end else begin : g_body
         assign right_valid = cell_valid[i+1];
         assign right_key   = cell_key[i+1];
         assign right_id    = cell_id[i+1];
      end

      stq_cell #(
         .KEY_BITS (KEY_BITS),
         .ID_BITS  (ID_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_key     (key_ff),
         .new_id      (id_ff),
         .left_valid  (left_valid),
         .left_key    (left_key),
         .left_id     (left_id),
         .right_valid (right_valid),
         .right_key   (right_key),
         .right_id    (right_id),
         .prior_in    (prior[i]),
         .prior_out   (prior[i+1]),
         .slot_valid  (cell_valid[i]),
         .slot_key    (cell_key[i]),
         .slot_id     (cell_id[i])
      );
   end

   // ---------------- controller: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (accept) state_in = S_COMPARE;
         S_COMPARE: state_in = S_UPDATE;
         S_UPDATE:  state_in = S_REPLY;
         S_REPLY:   if (load_rsp) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // ---------------- controller: outputs ----------------
   always_comb begin
      ctl       = '0;
      count_in  = count_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
         end
         S_COMPARE: begin
            // all cells compare against the captured operand at once
            ctl.capture = 1'b1;
            ctl.by_key  = (op_ff == OP_SORTED) && (key_ff != TAIL_KEY);
            ctl.by_id   = (op_ff == OP_REMOVE);
         end
         S_UPDATE: begin
            status_in = ST_DONE;
            if (is_insert) begin
               if (count_ff == FULL_COUNT) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.do_insert = 1'b1;
                  count_in      = count_ff + 1'b1;
               end
            end else if (op_ff == OP_REMOVE) begin
               if (found) begin
                  ctl.do_remove = 1'b1;
                  count_in      = count_ff - 1'b1;
               end else begin
                  status_in = ST_MISSING;
               end
            end
         end
         S_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_DONE;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   // hold the operand for the whole operation
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_chan.op;
         key_ff <= req_chan.sort_key;
         id_ff  <= req_chan.item_id;
      end
   end

   // load the result once the list has settled; empty list reads as zero
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_count_ff      <= count_ff;
         rsp_status_ff     <= status_ff;
         rsp_head_valid_ff <= cell_valid[0];
         rsp_head_key_ff   <= cell_valid[0] ? cell_key[0] : '0;
         rsp_head_id_ff    <= cell_valid[0] ? cell_id[0] : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.head_valid  = rsp_head_valid_ff;
   assign rsp_chan.head_key    = rsp_head_key_ff;
   assign rsp_chan.head_id     = rsp_head_id_ff;

   // ---------------- assertions ----------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("valid cells disagree with entry count");

   a_packed_row: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("head cell empty while list holds entries");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY && status_ff == ST_FULL) |-> count_ff == FULL_COUNT)
      else $error("full status reported below capacity");

endmodule
